// ----- rtl/css_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_pkg: shared types and constants for the scanline disc span block
// Configuration layout, stage payloads and root pipeline geometry.
// ----------------------------------------------------------------------------
package css_pkg;

	// row coordinate bits actually used from the 12 bit row field
	localparam int COORD_BITS = 12;
	localparam int ROW_W      = 12;
	localparam logic [ROW_W-1:0] ROW_MASK =
		(COORD_BITS >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((1 << COORD_BITS) - 1);

	localparam int CFG_DATA_W = 14;
	localparam int CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd4;

	// radius is at most 4095, so the radicand fits 24 bits and the root 12
	localparam int OFF_W      = 12;
	localparam int SQ_W       = 2 * OFF_W;
	localparam int ROOT_CELLS = OFF_W;

	typedef struct packed {
		logic [12:0]        width;
		logic [12:0]        height;
		logic signed [13:0] cx;
		logic signed [13:0] cy;
		logic signed [12:0] radius;
	} cfg_t;

	typedef struct packed {
		logic             hit;
		logic [ROW_W-1:0] row;
	} meta_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
		meta_t           meta;
	} root_t;

	// trial bit of root cell idx, from the top pair of bits downward
	function automatic logic [SQ_W-1:0] trial_bit(input int idx);
		logic [SQ_W-1:0] r;
		r = SQ_W'(1) << (2 * (ROOT_CELLS - 1 - idx));
		return r;
	endfunction

endpackage

// ----- rtl/circle_scanline_span_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_scanline_span_top: horizontal span of a filled disc per scanline
// Top level: configuration registers, front stages, root chain, back stages.
// ----------------------------------------------------------------------------
// Usage:
//   Write the surface size, disc centre and radius through cfg_we, cfg_index
//   and cfg_data while no transaction is in flight; indexes past the list are
//   ignored. Every input transaction carries one row_index and yields exactly
//   one output transaction with span_begin, span_end, span_present and
//   row_echo; empty spans report zero end points.
//   The pipe holds three front stages (|dy|, dy^2, r^2 - dy^2), twelve root
//   cells that each settle one bit of the square root, and two back stages
//   (end points, clamp). Throughput is one row per cycle while out_stall is
//   low; the root chain is most of the pipe and every stage is a register.
//   Each stage advances when it is empty or its successor advances, so
//   bubbles close up while out_stall is high and the input stalls only once
//   all 17 stages hold results. Reset empties the pipe and clears all
//   configuration registers to zero, which gives empty spans.
// ----------------------------------------------------------------------------
module circle_scanline_span_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [css_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [css_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [css_pkg::ROW_W-1:0]       row_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [12:0]                     span_begin,
	output logic [12:0]                     span_end,
	output logic                            span_present,
	output logic [css_pkg::ROW_W-1:0]       row_echo
);

	css_pkg::cfg_t   cfg_q;
	logic            in_ready;

	css_pkg::root_t  lane       [css_pkg::ROOT_CELLS+1];
	logic            lane_valid [css_pkg::ROOT_CELLS+1];
	logic            lane_ready [css_pkg::ROOT_CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				css_pkg::REG_WIDTH:  cfg_q.width  <= cfg_data[12:0];
				css_pkg::REG_HEIGHT: cfg_q.height <= cfg_data[12:0];
				css_pkg::REG_CX:     cfg_q.cx     <= $signed(cfg_data);
				css_pkg::REG_CY:     cfg_q.cy     <= $signed(cfg_data);
				css_pkg::REG_RADIUS: cfg_q.radius <= $signed(cfg_data[12:0]);
				default: ;
			endcase
		end
	end

	css_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.row      (row_index),
		.dn_valid (lane_valid[0]),
		.dn_ready (lane_ready[0]),
		.dn_data  (lane[0])
	);

	assign in_stall = !in_ready;

	for (genvar i = 0; i < css_pkg::ROOT_CELLS; i++) begin : g_root
		css_root_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.trial    (css_pkg::trial_bit(i)),
			.up_valid (lane_valid[i]),
			.up_ready (lane_ready[i]),
			.up_data  (lane[i]),
			.dn_valid (lane_valid[i+1]),
			.dn_ready (lane_ready[i+1]),
			.dn_data  (lane[i+1])
		);
	end

	css_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.up_valid     (lane_valid[css_pkg::ROOT_CELLS]),
		.up_ready     (lane_ready[css_pkg::ROOT_CELLS]),
		.up_data      (lane[css_pkg::ROOT_CELLS]),
		.dn_valid     (out_valid),
		.dn_ready     (!out_stall),
		.span_begin   (span_begin),
		.span_end     (span_end),
		.span_present (span_present),
		.row_echo     (row_echo)
	);

	// the input can only stall once the result register is occupied
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty output stage");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !span_present |-> span_begin == 13'd0 && span_end == 13'd0)
		else $error("empty span with nonzero end points");

	a_span_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && span_present |-> span_begin < span_end)
		else $error("present span not ordered");

	// a stalled result must stay valid and keep its row
	a_stall_holds_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_echo))
		else $error("stalled result lost its row");

endmodule

// ----- rtl/css_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_front: row distance and radicand stages
// Finds |dy| and the row hit test, squares |dy| and forms r^2 - dy^2.
// ----------------------------------------------------------------------------
module css_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  css_pkg::cfg_t              cfg,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  logic [css_pkg::ROW_W-1:0]  row,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output css_pkg::root_t             dn_data
);

	logic                          vld_s1, vld_s2, vld_s3;
	logic                          rdy_s1, rdy_s2, rdy_s3;
	css_pkg::meta_t                meta_s1, meta_s2, meta_s3;
	logic [css_pkg::OFF_W-1:0]     ady_s1;
	logic [css_pkg::SQ_W-1:0]      adysq_s2;
	logic [css_pkg::SQ_W-1:0]      rem_s3;
	logic [css_pkg::SQ_W-1:0]      rsq_q;

	logic [css_pkg::ROW_W-1:0]     row_m;
	logic signed [14:0]            dy;
	logic [14:0]                   ady;
	logic                          hit;

	assign rdy_s3   = !vld_s3 || dn_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_comb begin
		row_m = row & css_pkg::ROW_MASK;
		dy    = $signed({3'b000, row_m}) - $signed({cfg.cy[13], cfg.cy});
		ady   = dy[14] ? 15'(-dy) : 15'(dy);
		hit   = !cfg.radius[12] && (cfg.radius != 13'sd0)
			&& ({1'b0, row_m} < cfg.height)
			&& (ady <= {2'b00, cfg.radius});
	end

	// user changes radius only while idle (unenforced); its square is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsq_q <= '0;
		end else begin
			rsq_q <= cfg.radius[css_pkg::OFF_W-1:0] * cfg.radius[css_pkg::OFF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= up_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			meta_s1 <= '{hit: hit, row: row_m};
			ady_s1  <= ady[css_pkg::OFF_W-1:0];
		end
		if (rdy_s2 && vld_s1) begin
			meta_s2  <= meta_s1;
			adysq_s2 <= ady_s1 * ady_s1;
		end
		if (rdy_s3 && vld_s2) begin
			meta_s3 <= meta_s2;
			rem_s3  <= rsq_q - adysq_s2;
		end
	end

	assign dn_valid = vld_s3;
	assign dn_data  = '{rem: rem_s3, root: '0, meta: meta_s3};

endmodule

// ----- rtl/css_root_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_root_cell: one step of the integer square root chain
// Tests one root bit against the remainder and passes the result on.
// ----------------------------------------------------------------------------
module css_root_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [css_pkg::SQ_W-1:0]  trial,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  css_pkg::root_t            up_data,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output css_pkg::root_t            dn_data
);

	logic                  vld_q;
	css_pkg::root_t        data_q;
	css_pkg::root_t        nxt;
	logic [css_pkg::SQ_W:0] sum;

	assign up_ready = !vld_q || dn_ready;

	always_comb begin
		nxt = up_data;
		sum = {1'b0, up_data.root} + {1'b0, trial};
		if ({1'b0, up_data.rem} >= sum) begin
			nxt.rem  = up_data.rem - sum[css_pkg::SQ_W-1:0];
			nxt.root = (up_data.root >> 1) + trial;
		end else begin
			nxt.root = up_data.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = vld_q;
	assign dn_data  = data_q;

endmodule

// ----- rtl/css_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_back: span end points and clamping
// Forms cx - off and cx + off + 1, clamps both to the width, zeroes empty spans.
// ----------------------------------------------------------------------------
module css_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  css_pkg::cfg_t              cfg,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  css_pkg::root_t             up_data,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output logic [12:0]                span_begin,
	output logic [12:0]                span_end,
	output logic                       span_present,
	output logic [css_pkg::ROW_W-1:0]  row_echo
);

	logic                       vld_s1, vld_s2;
	logic                       rdy_s1, rdy_s2;
	css_pkg::meta_t             meta_s1;
	logic signed [15:0]         beg_s1, end_s1;
	logic [12:0]                beg_s2, end_s2;
	logic                       pres_s2;
	logic [css_pkg::ROW_W-1:0]  row_s2;

	logic signed [15:0]         cx16, off16;
	logic signed [15:0]         w16, bc, ec;
	logic                       pres;

	assign rdy_s2   = !vld_s2 || dn_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_comb begin
		cx16  = $signed({{2{cfg.cx[13]}}, cfg.cx});
		off16 = $signed({4'b0000, up_data.root[css_pkg::OFF_W-1:0]});
		w16   = $signed({3'b000, cfg.width});
		bc    = beg_s1[15] ? 16'sd0 : ((beg_s1 > w16) ? w16 : beg_s1);
		ec    = end_s1[15] ? 16'sd0 : ((end_s1 > w16) ? w16 : end_s1);
		pres  = meta_s1.hit && (bc < ec);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= up_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			meta_s1 <= up_data.meta;
			beg_s1  <= cx16 - off16;
			end_s1  <= cx16 + off16 + 16'sd1;
		end
		if (rdy_s2 && vld_s1) begin
			// empty spans report zero end points
			pres_s2 <= pres;
			beg_s2  <= pres ? bc[12:0] : 13'd0;
			end_s2  <= pres ? ec[12:0] : 13'd0;
			row_s2  <= meta_s1.row;
		end
	end

	assign dn_valid     = vld_s2;
	assign span_begin   = beg_s2;
	assign span_end     = end_s2;
	assign span_present = pres_s2;
	assign row_echo     = row_s2;

endmodule
